FILE: hw/rtl/ase_pkg.sv
// Shared types and constants for the execute stage of the small ARM-like core.
// Holds the request/response packing, the opcode and shift codes and the memory size.
// No dependencies.
package ase_pkg;

   localparam int MemWords = 1024;
   localparam int MemIdxW  = $clog2(MemWords);
   localparam int RegCount = 16;
   localparam int RegIdxW  = 4;

   localparam logic [RegIdxW-1:0] PcReg   = 4'd15;
   localparam logic [RegIdxW-1:0] LinkReg = 4'd14;

   localparam int ReqDataW = 88;
   localparam int RspDataW = 104;

   typedef enum logic [3:0] {
      FUNC_ADD = 4'd0,
      FUNC_SUB = 4'd1,
      FUNC_AND = 4'd2,
      FUNC_ORR = 4'd3,
      FUNC_EOR = 4'd4,
      FUNC_MOV = 4'd5,
      FUNC_CMP = 4'd6,
      FUNC_LDR = 4'd7,
      FUNC_STR = 4'd8,
      FUNC_B   = 4'd9,
      FUNC_BL  = 4'd10
   } func_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_type;

   // Packed with the first field in the highest bits.
   typedef struct packed {
      logic [2:0]         pad;
      logic signed [25:0] jump_offset;
      logic               base_update;
      logic               offset_up;
      logic [31:0]        imm_value;
      logic [4:0]         shift_amount;
      logic [1:0]         shift_kind;
      logic [3:0]         shift_src_reg;
      logic               use_shifted_reg;
      logic [3:0]         base_reg;
      logic [3:0]         dest_reg;
      logic               set_flags;
      logic [3:0]         func;
   } req_type;

   typedef struct packed {
      logic [2:0]  pad;
      logic        bad_opcode;
      logic [31:0] access_address;
      logic [31:0] data_value;
      logic [3:0]  flags_nzcv;
      logic [31:0] pc_after;
   } rsp_type;

endpackage

FILE: hw/rtl/arm_subset_execute_stage.sv
// Execute stage: one decoded instruction per request over a 16x32 register file,
// NZCV flags and a word data memory. Depends on ase_pkg.
// Pipeline: an accepted request is registered in req_ff and its result in rsp_ff, which
// drives the response. Throughput: one request per cycle while rsp_tready takes responses;
// a loaded word is forwarded to the next one. Reset: registers and flags clear at once,
// then a pass clears the data memory one word per cycle, during which req_tready stays low.
module arm_subset_execute_stage
   import ase_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // From bit 0: func, set_flags, dest_reg, base_reg, use_shifted_reg, shift_src_reg,
   // shift_kind, shift_amount, imm_value, offset_up, base_update, jump_offset, zero pad.
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // From bit 0: pc_after, flags_nzcv, data_value, access_address, bad_opcode, zero pad.
   output logic [RspDataW-1:0] rsp_tdata
);

   logic                clearing_ff, clearing_in;
   logic [MemIdxW-1:0]  clr_idx_ff, clr_idx_in;
   logic                v1_ff, v1_in;
   logic                v2_ff, v2_in;
   req_type             req_ff, req_in;
   rsp_type             rsp_ff, rsp_in, rsp_out;
   logic                is_load_ff, is_load_in;
   logic                load_pc_ff, load_pc_in;
   logic                pend_ff, pend_in;
   logic [RegIdxW-1:0]  pend_idx_ff, pend_idx_in;
   logic [3:0]          flags_ff, flags_in;
   logic [31:0]         rf_ff [RegCount];
   logic [31:0]         rf_view [RegCount];
   logic [31:0]         rf_exec [RegCount];
   logic [31:0]         rf_in [RegCount];
   logic [31:0]         mem [MemWords];
   logic [31:0]         mem_rdata_ff;

   logic                req_accept, s2_free, fire1;

   logic                bad, is_ldr, is_str, is_mem, is_branch, is_bl;
   logic                wr_en, sub_sel, upd_nzcv, upd_nz, logic_op;
   logic [31:0]         pc_adv, pc_read, op1, sh_src, shifted, op2;
   logic [32:0]         sum;
   logic [31:0]         arith_res, logic_res, alu_res, addr, target, str_data, data_val;
   logic                carry, ovf;
   logic [RegIdxW-1:0]  wr_idx;
   logic [MemIdxW-1:0]  mem_idx, mem_waddr;
   logic                mem_we;
   logic [31:0]         mem_wdata;

   assign s2_free    = !v2_ff || rsp_tready;
   assign fire1      = v1_ff && s2_free;
   assign req_tready = !clearing_ff && (!v1_ff || s2_free);
   assign req_accept = req_tvalid && req_tready;
   assign req_in     = req_type'(req_tdata);

   always_comb begin
      for (int i = 0; i < RegCount; i++) begin
         if (pend_ff && (pend_idx_ff == RegIdxW'(i))) begin
            rf_view[i] = mem_rdata_ff;
         end else begin
            rf_view[i] = rf_ff[i];
         end
      end
   end

   always_comb begin
      bad       = 1'b0;
      is_ldr    = 1'b0;
      is_str    = 1'b0;
      is_branch = 1'b0;
      is_bl     = 1'b0;
      wr_en     = 1'b0;
      logic_op  = 1'b0;
      upd_nzcv  = 1'b0;
      upd_nz    = 1'b0;
      unique case (req_ff.func)
         FUNC_ADD, FUNC_SUB: begin
            wr_en    = 1'b1;
            upd_nzcv = req_ff.set_flags;
         end
         FUNC_AND, FUNC_ORR, FUNC_EOR, FUNC_MOV: begin
            wr_en    = 1'b1;
            logic_op = 1'b1;
            upd_nz   = req_ff.set_flags;
         end
         FUNC_CMP: begin
            upd_nzcv = 1'b1;
         end
         FUNC_LDR: begin
            is_ldr = 1'b1;
         end
         FUNC_STR: begin
            is_str = 1'b1;
         end
         FUNC_B: begin
            is_branch = 1'b1;
         end
         FUNC_BL: begin
            is_branch = 1'b1;
            is_bl     = 1'b1;
            wr_en     = 1'b1;
         end
         default: begin
            bad = 1'b1;
         end
      endcase
      is_mem  = is_ldr || is_str;
      sub_sel = (req_ff.func == FUNC_SUB) || (req_ff.func == FUNC_CMP)
                || (is_mem && !req_ff.offset_up);
      wr_idx  = is_bl ? LinkReg : req_ff.dest_reg;
   end

   always_comb begin
      pc_adv  = rf_view[PcReg] + 32'd4;
      pc_read = pc_adv + 32'd4;
      op1     = (req_ff.base_reg == PcReg) ? pc_read : rf_view[req_ff.base_reg];
      sh_src  = (req_ff.shift_src_reg == PcReg) ? pc_read : rf_view[req_ff.shift_src_reg];

      if (req_ff.shift_amount == 5'd0) begin
         shifted = sh_src;
      end else begin
         unique case (shift_type'(req_ff.shift_kind))
            SHIFT_LSL: shifted = sh_src << req_ff.shift_amount;
            SHIFT_LSR: shifted = sh_src >> req_ff.shift_amount;
            SHIFT_ASR: shifted = 32'($signed(sh_src) >>> req_ff.shift_amount);
            SHIFT_ROR: shifted = (sh_src >> req_ff.shift_amount)
                                 | (sh_src << (6'd32 - {1'b0, req_ff.shift_amount}));
         endcase
      end
      op2 = req_ff.use_shifted_reg ? shifted : req_ff.imm_value;

      sum       = {1'b0, op1} + {1'b0, op2 ^ {32{sub_sel}}} + {32'd0, sub_sel};
      arith_res = sum[31:0];
      carry     = sum[32];
      if (sub_sel) begin
         ovf = ((op1 ^ op2) & (op1 ^ arith_res)) >> 31 != 32'd0;
      end else begin
         ovf = (~(op1 ^ op2) & (op1 ^ arith_res)) >> 31 != 32'd0;
      end

      unique case (req_ff.func)
         FUNC_AND: logic_res = op1 & op2;
         FUNC_ORR: logic_res = op1 | op2;
         FUNC_EOR: logic_res = op1 ^ op2;
         default:  logic_res = op2;
      endcase

      if (is_bl) begin
         alu_res = pc_adv;
      end else if (logic_op) begin
         alu_res = logic_res;
      end else begin
         alu_res = arith_res;
      end

      addr     = is_mem ? arith_res : 32'd0;
      mem_idx  = arith_res[MemIdxW+1:2];
      target   = pc_adv + {{6{req_ff.jump_offset[25]}}, req_ff.jump_offset} + 32'd4;
      str_data = (req_ff.dest_reg == PcReg) ? pc_adv : rf_view[req_ff.dest_reg];

      if (bad || req_ff.func == FUNC_CMP || (is_branch && !is_bl)) begin
         data_val = 32'd0;
      end else if (is_str) begin
         data_val = str_data;
      end else begin
         data_val = alu_res;
      end
   end

   always_comb begin
      for (int i = 0; i < RegCount; i++) begin
         rf_exec[i] = rf_view[i];
      end
      rf_exec[PcReg] = is_branch ? target : pc_adv;
      if (wr_en) begin
         rf_exec[wr_idx] = alu_res;
      end
      if (is_mem && req_ff.base_update) begin
         rf_exec[req_ff.base_reg] = arith_res;
      end
      for (int i = 0; i < RegCount; i++) begin
         rf_in[i] = (fire1 && !bad) ? rf_exec[i] : rf_view[i];
      end
   end

   always_comb begin
      flags_in = flags_ff;
      if (fire1 && upd_nzcv) begin
         flags_in = {arith_res[31], arith_res == 32'd0, carry, ovf};
      end else if (fire1 && upd_nz) begin
         flags_in = {logic_res[31], logic_res == 32'd0, flags_ff[1:0]};
      end

      pend_in     = fire1 && is_ldr
                    && !(req_ff.base_update && req_ff.base_reg == req_ff.dest_reg);
      pend_idx_in = req_ff.dest_reg;
      is_load_in  = is_ldr;
      load_pc_in  = is_ldr && (req_ff.dest_reg == PcReg)
                    && !(req_ff.base_update && req_ff.base_reg == PcReg);

      rsp_in.pad            = 3'd0;
      rsp_in.bad_opcode     = bad;
      rsp_in.access_address = bad ? 32'd0 : addr;
      rsp_in.data_value     = data_val;
      rsp_in.flags_nzcv     = flags_in;
      rsp_in.pc_after       = bad ? rf_view[PcReg] : rf_exec[PcReg];

      v1_in = req_accept ? 1'b1 : (fire1 ? 1'b0 : v1_ff);
      v2_in = fire1 ? 1'b1 : (rsp_tready ? 1'b0 : v2_ff);

      clearing_in = clearing_ff && (clr_idx_ff != {MemIdxW{1'b1}});
      clr_idx_in  = clearing_ff ? clr_idx_ff + 1'b1 : clr_idx_ff;

      mem_we    = clearing_ff || (fire1 && is_str);
      mem_waddr = clearing_ff ? clr_idx_ff : mem_idx;
      mem_wdata = clearing_ff ? 32'd0 : str_data;
   end

   always_comb begin
      rsp_out = rsp_ff;
      if (load_pc_ff) begin
         rsp_out.pc_after = mem_rdata_ff;
      end
      if (is_load_ff) begin
         rsp_out.data_value = mem_rdata_ff;
      end
   end

   assign rsp_tvalid = v2_ff;
   assign rsp_tdata  = rsp_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         pend_ff     <= 1'b0;
         flags_ff    <= 4'd0;
         for (int i = 0; i < RegCount; i++) begin
            rf_ff[i] <= 32'd0;
         end
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         pend_ff     <= pend_in;
         flags_ff    <= flags_in;
         for (int i = 0; i < RegCount; i++) begin
            rf_ff[i] <= rf_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      if (req_accept) begin
         req_ff <= req_in;
      end
      if (fire1) begin
         rsp_ff     <= rsp_in;
         is_load_ff <= is_load_in;
         load_pc_ff <= load_pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (fire1) begin
         mem_rdata_ff <= mem[mem_idx];
      end
   end

`ifndef ASSERT_OFF
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (!req_tready && !v1_ff && !v2_ff))
      else $error("request stage active during memory clear");

   a_pend_after_fire: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(fire1))
      else $error("load write-back pending without a preceding execute");

   a_bad_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      (fire1 && bad) |=> (rf_ff[PcReg] == $past(rf_view[PcReg]) && !pend_ff))
      else $error("invalid opcode changed the program counter");

   a_bad_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && rsp_ff.bad_opcode) |-> (rsp_out.data_value == 32'd0
                                        && rsp_out.access_address == 32'd0))
      else $error("invalid opcode response carries data");
`endif

endmodule
